// ----- rtl/core/gcfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// gcfsp_pkg
// Shared types and constants of the conflict-free set partition block.
// ----------------------------------------------------------------------------
package gcfsp_pkg;

  localparam int unsigned REG_W = 13;
  localparam int unsigned IDX_W = 10;

  typedef enum logic [2:0] {
    REG_MIN_SEP_X = 3'd0,
    REG_MIN_SEP_Y = 3'd1,
    REG_MIN_SEP_Z = 3'd2,
    REG_GRID_X    = 3'd3,
    REG_GRID_Y    = 3'd4,
    REG_GRID_Z    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] sep_x;
    logic [REG_W-1:0] sep_y;
    logic [REG_W-1:0] sep_z;
    logic [REG_W-1:0] grid_x;
    logic [REG_W-1:0] grid_y;
    logic [REG_W-1:0] grid_z;
  } sep_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN,
    ST_SCAN,
    ST_FETCH,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_SWAP_WR2,
    ST_CLOSE,
    ST_READ
  } state_t;

endpackage

// ----- rtl/core/gcfsp_clash.sv -----
// ----------------------------------------------------------------------------
// gcfsp_clash
// Separation check of two points on three axes with wrapped distance.
// ----------------------------------------------------------------------------
module gcfsp_clash #(
  parameter int COORD_BITS = 12
) (
  input  logic [3*COORD_BITS-1:0] pt_a,
  input  logic [3*COORD_BITS-1:0] pt_b,
  input  gcfsp_pkg::sep_cfg_t     cfg,
  output logic                    clash
);

  localparam int DW = COORD_BITS + 15;

  function automatic logic axis_clash(input logic [COORD_BITS-1:0] a,
                                      input logic [COORD_BITS-1:0] b,
                                      input logic [gcfsp_pkg::REG_W-1:0] sep,
                                      input logic [gcfsp_pkg::REG_W-1:0] grid);
    logic signed [DW-1:0] sa;
    logic signed [DW-1:0] sb;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] s;
    logic signed [DW-1:0] g;
    sa = DW'($signed(a));
    sb = DW'($signed(b));
    d  = sa - sb;
    if (d < 0) begin
      d = -d;
    end
    s = $signed(DW'(sep));
    g = $signed(DW'(grid));
    return (d < s) || ((g - d) < s);
  endfunction

  assign clash =
    axis_clash(pt_a[3*COORD_BITS-1:2*COORD_BITS], pt_b[3*COORD_BITS-1:2*COORD_BITS],
               cfg.sep_x, cfg.grid_x) ||
    axis_clash(pt_a[2*COORD_BITS-1:COORD_BITS], pt_b[2*COORD_BITS-1:COORD_BITS],
               cfg.sep_y, cfg.grid_y) ||
    axis_clash(pt_a[COORD_BITS-1:0], pt_b[COORD_BITS-1:0], cfg.sep_z, cfg.grid_z);

endmodule

// ----- rtl/core/greedy_conflict_free_set_partition.sv -----
// ----------------------------------------------------------------------------
// greedy_conflict_free_set_partition
// Loads grid points, partitions them greedily into conflict-free sets and
// returns one partition entry per read while unread entries remain.
// ----------------------------------------------------------------------------
// A load is op 0. The first read after loading runs the
// partition over the point memory before it answers: every candidate is
// fetched, then checked against each set member in turn (one memory read
// port), then swapped in if it fits; each set is opened, ended by a scan
// check and closed, and the whole pass ends with a final open and the read
// launch. The worst case grows with the square of the point count.
// Afterwards a read passes the memory read register, then the output
// register; a read waits while a result beat is valid.
// The memories need no clearing after reset.
module greedy_conflict_free_set_partition #(
  parameter int MAX_POINTS = 1024,
  parameter int SET_MAX    = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [COORD_BITS-1:0] in_coord_x,
  input  logic [COORD_BITS-1:0] in_coord_y,
  input  logic [COORD_BITS-1:0] in_coord_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [9:0]            out_point_index,
  output logic [9:0]            out_set_number,
  output logic                  out_last_in_set,
  output logic                  out_last_overall,
  output logic                  out_overflow,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [12:0]           cfg_wdata
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int PW  = 3 * COORD_BITS;
  localparam int IW  = gcfsp_pkg::IDX_W;
  localparam int SW  = IW + 1;
  localparam int MW  = PW + IW;

  gcfsp_pkg::sep_cfg_t cfg_r;
  gcfsp_pkg::state_t   state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] read_pos_r, read_pos_nxt;
  logic [CW-1:0] set_start_r, set_start_nxt;
  logic [CW-1:0] set_end_r, set_end_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [IW-1:0] set_no_r, set_no_nxt;
  logic          done_r, done_nxt;
  logic          ovf_r, ovf_nxt;
  logic [PW-1:0] cand_r, cand_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic          pend_ovf_r, pend_ovf_nxt;
  logic          out_valid_r;
  logic [IW-1:0] out_idx_r;
  logic [IW-1:0] out_set_r;
  logic          out_lis_r, out_lo_r, out_ovf_r;

  // index of the candidate, captured with its coordinates
  logic [IW-1:0] idx_keep_r;

  logic [MW-1:0] slot_mem [MAX_POINTS];
  logic [SW-1:0] set_mem  [MAX_POINTS];
  logic [MW-1:0] slot_rdata_r;
  logic [SW-1:0] set_rdata_r;

  logic          slot_we;
  logic [AW-1:0] slot_waddr;
  logic [MW-1:0] slot_wdata;
  logic          set_we;
  logic [AW-1:0] set_waddr;
  logic [SW-1:0] set_wdata;
  logic [AW-1:0] raddr;

  logic          in_acc;
  logic          clash;
  logic [CW:0]   rp_inc;
  logic [CW-1:0] k_inc;

  gcfsp_clash #(.COORD_BITS(COORD_BITS)) u_clash (
    .pt_a  (cand_r),
    .pt_b  (slot_rdata_r[MW-1:IW]),
    .cfg   (cfg_r),
    .clash (clash)
  );

  assign in_ready = (state_r == gcfsp_pkg::ST_IDLE) && !rd_pend_r && !(in_op && out_valid_r);
  assign in_acc   = in_valid && in_ready;
  assign rp_inc   = {1'b0, read_pos_r} + 1'b1;
  assign k_inc    = k_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    read_pos_nxt  = read_pos_r;
    set_start_nxt = set_start_r;
    set_end_nxt   = set_end_r;
    scan_nxt      = scan_r;
    k_nxt         = k_r;
    set_no_nxt    = set_no_r;
    done_nxt      = done_r;
    ovf_nxt       = ovf_r;
    cand_nxt      = cand_r;
    rd_pend_nxt   = 1'b0;
    pend_last_nxt = pend_last_r;
    pend_ovf_nxt  = pend_ovf_r;
    slot_we       = 1'b0;
    slot_waddr    = count_r[AW-1:0];
    slot_wdata    = {in_coord_x, in_coord_y, in_coord_z, IW'(count_r)};
    set_we        = 1'b0;
    set_waddr     = set_end_r[AW-1:0];
    set_wdata     = {set_no_r, 1'b0};
    raddr         = read_pos_r[AW-1:0];

    case (state_r)
      gcfsp_pkg::ST_IDLE: begin
        if (in_acc && !in_op) begin
          if (done_r) begin
            count_nxt    = CW'(1);
            read_pos_nxt = '0;
            done_nxt     = 1'b0;
            ovf_nxt      = 1'b0;
            slot_we      = 1'b1;
            slot_waddr   = '0;
            slot_wdata   = {in_coord_x, in_coord_y, in_coord_z, IW'(0)};
          end else if (32'(count_r) >= MAX_POINTS) begin
            ovf_nxt = 1'b1;
          end else begin
            slot_we   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end else if (in_acc && in_op && (count_r != '0)) begin
          if (!done_r) begin
            set_start_nxt = '0;
            set_no_nxt    = '0;
            state_nxt     = gcfsp_pkg::ST_OPEN;
          end else if (read_pos_r < count_r) begin
            rd_pend_nxt   = 1'b1;
            pend_last_nxt = rp_inc >= {1'b0, count_r};
            pend_ovf_nxt  = ovf_r;
            read_pos_nxt  = rp_inc[CW-1:0];
          end
        end
      end
      gcfsp_pkg::ST_OPEN: begin
        if (set_start_r >= count_r) begin
          done_nxt  = 1'b1;
          state_nxt = gcfsp_pkg::ST_READ;
        end else begin
          set_end_nxt = set_start_r + 1'b1;
          scan_nxt    = set_start_r + 1'b1;
          set_we      = 1'b1;
          set_waddr   = set_start_r[AW-1:0];
          state_nxt   = gcfsp_pkg::ST_SCAN;
        end
      end
      gcfsp_pkg::ST_SCAN: begin
        raddr = scan_r[AW-1:0];
        if ((scan_r < count_r) && (32'(set_end_r - set_start_r) < SET_MAX)) begin
          state_nxt = gcfsp_pkg::ST_FETCH;
        end else begin
          state_nxt = gcfsp_pkg::ST_CLOSE;
        end
      end
      gcfsp_pkg::ST_FETCH: begin
        cand_nxt  = slot_rdata_r[MW-1:IW];
        k_nxt     = set_start_r;
        state_nxt = gcfsp_pkg::ST_CMP_RD;
      end
      gcfsp_pkg::ST_CMP_RD: begin
        raddr     = k_r[AW-1:0];
        state_nxt = gcfsp_pkg::ST_CMP_CHK;
      end
      gcfsp_pkg::ST_CMP_CHK: begin
        if (clash) begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = gcfsp_pkg::ST_SCAN;
        end else if (k_inc != set_end_r) begin
          k_nxt     = k_inc;
          state_nxt = gcfsp_pkg::ST_CMP_RD;
        end else if (scan_r == set_end_r) begin
          state_nxt = gcfsp_pkg::ST_SWAP_WR2;
        end else begin
          state_nxt = gcfsp_pkg::ST_SWAP_RD;
        end
      end
      gcfsp_pkg::ST_SWAP_RD: begin
        raddr     = set_end_r[AW-1:0];
        state_nxt = gcfsp_pkg::ST_SWAP_WR;
      end
      gcfsp_pkg::ST_SWAP_WR: begin
        slot_we    = 1'b1;
        slot_waddr = scan_r[AW-1:0];
        slot_wdata = slot_rdata_r;
        state_nxt  = gcfsp_pkg::ST_SWAP_WR2;
      end
      gcfsp_pkg::ST_SWAP_WR2: begin
        // the member index travels with the point; keep it from the scan slot
        slot_we     = 1'b1;
        slot_waddr  = set_end_r[AW-1:0];
        slot_wdata  = {cand_r, idx_keep_r};
        set_we      = 1'b1;
        set_end_nxt = set_end_r + 1'b1;
        scan_nxt    = scan_r + 1'b1;
        state_nxt   = gcfsp_pkg::ST_SCAN;
      end
      gcfsp_pkg::ST_CLOSE: begin
        set_we        = 1'b1;
        set_waddr     = AW'(set_end_r - 1'b1);
        set_wdata     = {set_no_r, 1'b1};
        set_no_nxt    = set_no_r + 1'b1;
        set_start_nxt = set_end_r;
        state_nxt     = gcfsp_pkg::ST_OPEN;
      end
      gcfsp_pkg::ST_READ: begin
        rd_pend_nxt   = 1'b1;
        pend_last_nxt = rp_inc >= {1'b0, count_r};
        pend_ovf_nxt  = ovf_r;
        read_pos_nxt  = rp_inc[CW-1:0];
        state_nxt     = gcfsp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gcfsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == gcfsp_pkg::ST_FETCH) begin
      idx_keep_r <= slot_rdata_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (set_we) begin
      set_mem[set_waddr] <= set_wdata;
    end
    slot_rdata_r <= slot_mem[raddr];
    set_rdata_r  <= set_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcfsp_pkg::ST_IDLE;
      count_r     <= '0;
      read_pos_r  <= '0;
      set_start_r <= '0;
      set_end_r   <= '0;
      scan_r      <= '0;
      k_r         <= '0;
      set_no_r    <= '0;
      done_r      <= 1'b0;
      ovf_r       <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r.sep_x  <= 13'd1;
      cfg_r.sep_y  <= 13'd1;
      cfg_r.sep_z  <= 13'd1;
      cfg_r.grid_x <= 13'd256;
      cfg_r.grid_y <= 13'd256;
      cfg_r.grid_z <= 13'd256;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      read_pos_r  <= read_pos_nxt;
      set_start_r <= set_start_nxt;
      set_end_r   <= set_end_nxt;
      scan_r      <= scan_nxt;
      k_r         <= k_nxt;
      set_no_r    <= set_no_nxt;
      done_r      <= done_nxt;
      ovf_r       <= ovf_nxt;
      rd_pend_r   <= rd_pend_nxt;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          gcfsp_pkg::REG_MIN_SEP_X: cfg_r.sep_x  <= cfg_wdata;
          gcfsp_pkg::REG_MIN_SEP_Y: cfg_r.sep_y  <= cfg_wdata;
          gcfsp_pkg::REG_MIN_SEP_Z: cfg_r.sep_z  <= cfg_wdata;
          gcfsp_pkg::REG_GRID_X:    cfg_r.grid_x <= cfg_wdata;
          gcfsp_pkg::REG_GRID_Y:    cfg_r.grid_y <= cfg_wdata;
          gcfsp_pkg::REG_GRID_Z:    cfg_r.grid_z <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    pend_last_r <= pend_last_nxt;
    pend_ovf_r  <= pend_ovf_nxt;
    if (rd_pend_r) begin
      out_idx_r <= slot_rdata_r[IW-1:0];
      out_set_r <= set_rdata_r[SW-1:1];
      out_lis_r <= set_rdata_r[0];
      out_lo_r  <= pend_last_r;
      out_ovf_r <= pend_ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_index  = out_idx_r;
  assign out_set_number   = out_set_r;
  assign out_last_in_set  = out_lis_r;
  assign out_last_overall = out_lo_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ----- rtl/core/gcfsp_checker.sv -----
// ----------------------------------------------------------------------------
// gcfsp_checker
// Port-level checks of the set partition block, bound to the top level.
// ----------------------------------------------------------------------------
module gcfsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_point_index,
  input logic [9:0] out_set_number,
  input logic       out_last_in_set,
  input logic       out_last_overall
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_index)
      && $stable(out_set_number))
    else $error("result beat changed while stalled");

  // the final entry always closes its set
  a_last_closes_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_overall |-> out_last_in_set)
    else $error("last entry without last-in-set");

  // nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind greedy_conflict_free_set_partition gcfsp_checker u_gcfsp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_point_index  (out_point_index),
  .out_set_number   (out_set_number),
  .out_last_in_set  (out_last_in_set),
  .out_last_overall (out_last_overall)
);

// ----- test/greedy_conflict_free_set_partition_test.sv -----
// ----------------------------------------------------------------------------
// greedy_conflict_free_set_partition_test
// Loads batches of grid points, reads back the partition and compares every
// result beat with an in-bench model of the greedy set partition. Both
// channels stall at random; separations and grid sizes change between batches.
// ----------------------------------------------------------------------------
typedef struct {
  logic [9:0] point_index;
  logic [9:0] set_number;
  logic       last_in_set;
  logic       last_overall;
  logic       overflow;
} entry_t;

class partition_predictor;
  localparam int NPTS = 1024;
  localparam int SMAX = 256;
  int unsigned sep[3];
  int unsigned grid[3];
  int          crd[NPTS][3];
  int unsigned idx[NPTS];
  int unsigned setn[NPTS];
  int unsigned count, read_pos;
  bit          done, ovf;
  entry_t      pending_entries[$];
  int          errors, results, loads, reads;

  function new();
    for (int a = 0; a < 3; a++) begin
      sep[a]  = 1;
      grid[a] = 256;
    end
    count = 0;
    read_pos = 0;
    done = 0;
    ovf = 0;
  endfunction

  function void set_reg(gcfsp_pkg::reg_idx_t r, logic [12:0] v);
    case (r)
      gcfsp_pkg::REG_MIN_SEP_X: sep[0] = v;
      gcfsp_pkg::REG_MIN_SEP_Y: sep[1] = v;
      gcfsp_pkg::REG_MIN_SEP_Z: sep[2] = v;
      gcfsp_pkg::REG_GRID_X:    grid[0] = v;
      gcfsp_pkg::REG_GRID_Y:    grid[1] = v;
      gcfsp_pkg::REG_GRID_Z:    grid[2] = v;
      default: ;
    endcase
  endfunction

  function bit clash(int unsigned p, int unsigned q);
    int d;
    for (int a = 0; a < 3; a++) begin
      d = crd[p][a] - crd[q][a];
      if (d < 0) d = -d;
      if (d < int'(sep[a])) return 1;
      if ((int'(grid[a]) - d) < int'(sep[a])) return 1;
    end
    return 0;
  endfunction

  function void partition();
    int unsigned s0, s1, pos, sno, ti;
    int          tc;
    bit          ok;
    sno = 0;
    s0 = 0;
    while (s0 < count) begin
      s1 = s0 + 1;
      pos = s1;
      while (pos < count && s1 - s0 < SMAX) begin
        ok = 1;
        for (int unsigned k = s0; k < s1; k++)
          if (clash(pos, k)) begin
            ok = 0;
            break;
          end
        if (ok) begin
          for (int a = 0; a < 3; a++) begin
            tc = crd[pos][a];
            crd[pos][a] = crd[s1][a];
            crd[s1][a] = tc;
          end
          ti = idx[pos];
          idx[pos] = idx[s1];
          idx[s1] = ti;
          s1++;
        end
        pos++;
      end
      for (int unsigned k = s0; k < s1; k++) setn[k] = sno;
      sno++;
      s0 = s1;
    end
    done = 1;
  endfunction

  function void note_beat(logic op, logic signed [11:0] x, logic signed [11:0] y,
                          logic signed [11:0] z);
    entry_t e;
    int unsigned i;
    if (op == 1'b0) begin
      loads++;
      if (done) begin
        count = 0;
        read_pos = 0;
        done = 0;
        ovf = 0;
      end
      if (count >= NPTS) begin
        ovf = 1;
        return;
      end
      crd[count][0] = x;
      crd[count][1] = y;
      crd[count][2] = z;
      idx[count] = count;
      count++;
      return;
    end
    reads++;
    if (count == 0) return;
    if (!done) partition();
    if (read_pos >= count) return;
    i = read_pos++;
    e.point_index  = 10'(idx[i]);
    e.set_number   = 10'(setn[i]);
    e.last_in_set  = (i + 1 >= count) || (setn[i+1] != setn[i]);
    e.last_overall = (i + 1 >= count);
    e.overflow     = ovf;
    pending_entries = {pending_entries, e};
  endfunction

  function void check_beat(entry_t got);
    entry_t e;
    results++;
    if (pending_entries.size() == 0) begin
      $display("%0t: unexpected result beat index %0d set %0d", $time,
               got.point_index, got.set_number);
      errors++;
      return;
    end
    e = pending_entries.pop_front();
    if (got.point_index !== e.point_index) begin
      $display("%0t: point_index exp %0d got %0d", $time, e.point_index, got.point_index);
      errors++;
    end
    if (got.set_number !== e.set_number) begin
      $display("%0t: set_number exp %0d got %0d", $time, e.set_number, got.set_number);
      errors++;
    end
    if (got.last_in_set !== e.last_in_set) begin
      $display("%0t: last_in_set exp %0b got %0b", $time, e.last_in_set, got.last_in_set);
      errors++;
    end
    if (got.last_overall !== e.last_overall) begin
      $display("%0t: last_overall exp %0b got %0b", $time, e.last_overall, got.last_overall);
      errors++;
    end
    if (got.overflow !== e.overflow) begin
      $display("%0t: overflow exp %0b got %0b", $time, e.overflow, got.overflow);
      errors++;
    end
  endfunction
endclass

module greedy_conflict_free_set_partition_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam int   LIMIT   = 8_000_000;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_op;
  logic [11:0] in_coord_x, in_coord_y, in_coord_z;
  logic        out_valid, out_ready;
  logic [9:0]  out_point_index, out_set_number;
  logic        out_last_in_set, out_last_overall, out_overflow;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_wdata;

  partition_predictor board;
  bit          calm;
  int          cycles;
  int          batches;

  greedy_conflict_free_set_partition DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_point_index(out_point_index), .out_set_number(out_set_number),
    .out_last_in_set(out_last_in_set), .out_last_overall(out_last_overall),
    .out_overflow(out_overflow),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_valid = 0; in_op = 0; in_coord_x = 0; in_coord_y = 0; in_coord_z = 0;
    out_ready = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    rst_n = 0;
    board = new();
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 30);

  always @(posedge clk) begin
    entry_t got;
    if (rst_n && out_valid && out_ready) begin
      got.point_index  = out_point_index;
      got.set_number   = out_set_number;
      got.last_in_set  = out_last_in_set;
      got.last_overall = out_last_overall;
      got.overflow     = out_overflow;
      board.check_beat(got);
    end
  end

  task automatic send(logic op, logic [11:0] x, logic [11:0] y, logic [11:0] z);
    while (!calm && $urandom_range(99) < 30) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    in_op <= op;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    do @(posedge clk); while (!in_ready);
    board.note_beat(op, x, y, z);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (board.pending_entries.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [12:0] v[6]);
    drain();
    for (int r = 0; r < 6; r++) begin
      @(negedge clk);
      cfg_we <= 1;
      cfg_index <= r[2:0];
      cfg_wdata <= v[r];
      board.set_reg(gcfsp_pkg::reg_idx_t'(r), v[r]);
    end
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [12:0] pick_reg(bit is_grid);
    case ($urandom_range(7))
      0: return is_grid ? 13'd1 : 13'd0;
      1: return 13'd4096;
      2: return 13'($urandom_range(4096, is_grid));
      default: return is_grid ? 13'($urandom_range(64, 8)) : 13'($urandom_range(4, 0));
    endcase
  endfunction

  task automatic run_batch(int n, bit tight, int extra);
    for (int i = 0; i < n; i++)
      if (tight)
        send(OP_LOAD, 12'($signed($urandom_range(16)) - 8),
             12'($signed($urandom_range(16)) - 8), 12'($signed($urandom_range(16)) - 8));
      else
        send(OP_LOAD, 12'($urandom), 12'($urandom), 12'($urandom));
    for (int i = 0; i < extra; i++) send(OP_READ, 12'($urandom), 12'($urandom), 12'($urandom));
    batches++;
  endtask

  initial begin
    logic [12:0] v[6];
    int          n, sent;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: read with nothing loaded, coordinate extremes, read past end
    send(OP_READ, 12'h000, 12'h000, 12'h000);
    send(OP_LOAD, 12'h800, 12'h800, 12'h800);
    send(OP_LOAD, 12'h7FF, 12'h7FF, 12'h7FF);
    send(OP_LOAD, 12'h000, 12'h000, 12'h000);
    send(OP_LOAD, 12'h800, 12'h7FF, 12'h000);
    send(OP_LOAD, 12'hFFF, 12'h001, 12'h080);
    send(OP_LOAD, 12'h800, 12'h800, 12'h800);
    for (int i = 0; i < 8; i++) send(OP_READ, 12'hFFF, 12'hFFF, 12'hFFF);
    // tiny grid: every pair clashes
    v = '{13'd1, 13'd1, 13'd1, 13'd1, 13'd1, 13'd1};
    write_cfg(v);
    run_batch(5, 1, 6);
    // largest separation
    v = '{13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096};
    write_cfg(v);
    run_batch(4, 0, 5);
    // no separation: sets fill to the size cap; overfill the point store
    v = '{13'd0, 13'd0, 13'd0, 13'd4096, 13'd4096, 13'd4096};
    write_cfg(v);
    calm = 1;
    run_batch(300, 0, 0);
    calm = 0;
    run_batch(726, 0, 258);
    // load after a partial read starts a new batch
    v = '{13'd1, 13'd1, 13'd1, 13'd256, 13'd256, 13'd256};
    write_cfg(v);
    run_batch(6, 1, 3);
    run_batch(4, 1, 5);

    sent = 0;
    while (sent < 40) begin
      if ($urandom_range(3) == 0) begin
        for (int r = 0; r < 6; r++) v[r] = pick_reg(r >= 3);
        write_cfg(v);
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(8, 1);
      if ($urandom_range(7) == 0)
        run_batch(n, $urandom_range(1), $urandom_range(n, 0));
      else
        run_batch(n, $urandom_range(2) != 0, n + $urandom_range(2));
      sent += 2 * n;
    end
    calm = 0;
    drain();
    $display("covered %0d batches, %0d loads, %0d reads, %0d result beats",
             batches, board.loads, board.reads, board.results);
    if (board.errors == 0 && board.pending_entries.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
